// ----- hw/rtl/integer_field_scanner_macros.svh -----
// assertion macros for the integer field scanner
// used by modules that clock on i_clk with synchronous active-low reset i_rst_n
`ifndef INTEGER_FIELD_SCANNER_MACROS_SVH
`define INTEGER_FIELD_SCANNER_MACROS_SVH

// same-cycle implication
`define IFS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ifs: same-cycle check failed");

// next-cycle implication
`define IFS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ifs: next-cycle check failed");

`endif

// ----- hw/rtl/ifs_pkg.sv -----
// shared types and constants of the integer field scanner
// no dependencies
`timescale 1ns / 1ps

package ifs_pkg;

    localparam int unsigned OUT_BITS = 64;

    localparam logic [2:0] CONV_D = 3'd0;
    localparam logic [2:0] CONV_I = 3'd1;
    localparam logic [2:0] CONV_U = 3'd2;
    localparam logic [2:0] CONV_O = 3'd3;
    localparam logic [2:0] CONV_X = 3'd4;
    localparam logic [2:0] CONV_P = 3'd5;

    localparam logic [1:0] LEN_INT   = 2'd0;
    localparam logic [1:0] LEN_SHORT = 2'd1;
    localparam logic [1:0] LEN_LONG  = 2'd2;

    localparam logic [2:0] CFG_CONVERSION    = 3'd0;
    localparam logic [2:0] CFG_LENGTH_MODE   = 3'd1;
    localparam logic [2:0] CFG_WIDTH_LIMITED = 3'd2;
    localparam logic [2:0] CFG_MAX_WIDTH     = 3'd3;
    localparam logic [2:0] CFG_SUPPRESS      = 3'd4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CHAR  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SKIP     = 3'd1,
        PH_SIGNED_I = 3'd2,
        PH_ZERO_I   = 3'd3,
        PH_DIGITS   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RX_OCT = 2'd0,
        RX_DEC = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        logic [2:0] conversion;
        logic [1:0] length_mode;
        logic       width_limited;
        logic [7:0] max_width;
        logic       suppress;
    } t_cfg;

    typedef struct packed {
        logic       is_blank;
        logic       is_nul;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       oct_ok;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } t_char_class;

    typedef struct packed {
        logic                valid;
        logic [OUT_BITS-1:0] value;
        logic [15:0]         consumed;
        logic                used;
        logic                assigned;
    } t_result;

endpackage

// ----- hw/rtl/ifs_char_class.sv -----
// character classifier: whitespace, sign, prefix and digit decode of one byte
// depends on ifs_pkg
`timescale 1ns / 1ps

module ifs_char_class (
    input  logic [7:0]          i_ch,
    output ifs_pkg::t_char_class o_cls
);
    import ifs_pkg::*;

    logic num;
    logic lower_hex;
    logic upper_hex;
    logic x_char;

    always_comb begin
        num       = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        lower_hex = (i_ch >= 8'h61) && (i_ch <= 8'h66);
        upper_hex = (i_ch >= 8'h41) && (i_ch <= 8'h46);
        x_char    = (i_ch == 8'h78) || (i_ch == 8'h58);

        o_cls.is_blank = (i_ch == 8'h20) || (i_ch == 8'h0A) || (i_ch == 8'h09)
                      || (i_ch == 8'h0D) || (i_ch == 8'h0C);
        o_cls.is_nul   = (i_ch == 8'h00);
        o_cls.is_sign  = (i_ch == 8'h2B) || (i_ch == 8'h2D);
        o_cls.is_minus = (i_ch == 8'h2D);
        o_cls.is_zero  = (i_ch == 8'h30);
        o_cls.is_x     = x_char;
        o_cls.oct_ok   = (i_ch >= 8'h30) && (i_ch <= 8'h37);
        o_cls.dec_ok   = num;
        o_cls.hex_ok   = num || lower_hex || upper_hex || x_char;

        if (num) begin
            o_cls.digit = i_ch[3:0];
        end else if (lower_hex || upper_hex) begin
            o_cls.digit = 4'(i_ch[2:0] + 3'd1) + 4'd8;
        end else begin
            o_cls.digit = 4'd0;
        end
    end

endmodule

// ----- hw/rtl/ifs_scan_core.sv -----
// field scanner state machine, accumulator and result formatting
// depends on ifs_pkg, ifs_char_class and integer_field_scanner_macros.svh
`timescale 1ns / 1ps
`include "integer_field_scanner_macros.svh"

module ifs_scan_core #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_cmd,
    input  logic [7:0]       i_ch,
    input  ifs_pkg::t_cfg    i_cfg,
    output ifs_pkg::t_result o_res
);
    import ifs_pkg::*;

    localparam logic [OUT_BITS-1:0] ValueMask = {OUT_BITS{1'b1}} >> (OUT_BITS - VALUE_BITS);

    typedef struct packed {
        logic start;
        logic ws;
        logic take;
        logic accum;
        logic set_sign;
        logic load_oct;
        logic load_dec;
        logic load_hex;
        logic emit;
        logic used;
        logic nonnul;
    } t_ctl;

    t_phase                r_phase, n_phase;
    t_radix                r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic [7:0]            r_fc, n_fc;
    logic [15:0]           r_sc, n_sc;

    t_char_class           cls;
    t_ctl                  ctl;
    logic [2:0]            mode;
    logic                  mode_i;
    logic [7:0]            fc_inc;
    logic [15:0]           sc_inc;
    logic                  w_now;
    logic                  w_after;
    logic                  do_digit;
    logic                  dec_force;
    logic                  dig_ok;
    logic [VALUE_BITS-1:0] acc_next;
    logic [OUT_BITS-1:0]   acc_wide;
    logic [OUT_BITS-1:0]   signed_val;
    logic [OUT_BITS-1:0]   sized_val;
    logic                  sext;

    ifs_char_class u_class (
        .i_ch  (i_ch),
        .o_cls (cls)
    );

    always_comb begin
        mode    = (i_cfg.conversion > CONV_P) ? CONV_D : i_cfg.conversion;
        mode_i  = (mode == CONV_I);
        fc_inc  = (r_fc == 8'hFF) ? r_fc : r_fc + 8'd1;
        sc_inc  = (r_sc == 16'hFFFF) ? r_sc : r_sc + 16'd1;
        w_now   = i_cfg.width_limited && (r_fc >= i_cfg.max_width);
        w_after = i_cfg.width_limited && (fc_inc >= i_cfg.max_width);
    end

    // next state and control
    always_comb begin
        n_phase   = r_phase;
        ctl       = '0;
        do_digit  = 1'b0;
        dec_force = 1'b0;
        dig_ok    = 1'b0;
        if (i_step) begin
            if (i_cmd == CMD_START) begin
                n_phase   = PH_SKIP;
                ctl.start = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_SKIP: begin
                        if (cls.is_blank) begin
                            ctl.ws = 1'b1;
                        end else if (cls.is_nul) begin
                            ctl.emit = 1'b1;
                        end else if (cls.is_sign) begin
                            ctl.take     = 1'b1;
                            ctl.set_sign = 1'b1;
                            if (mode_i) begin
                                n_phase = PH_SIGNED_I;
                            end else if (w_after) begin
                                ctl.emit   = 1'b1;
                                ctl.used   = 1'b1;
                                ctl.nonnul = 1'b1;
                            end else begin
                                n_phase = PH_DIGITS;
                            end
                        end else if (mode_i && cls.is_zero) begin
                            ctl.take     = 1'b1;
                            ctl.load_oct = 1'b1;
                            n_phase      = PH_ZERO_I;
                        end else if (mode_i) begin
                            ctl.load_dec = 1'b1;
                            dec_force    = 1'b1;
                            do_digit     = 1'b1;
                        end else begin
                            do_digit = 1'b1;
                        end
                    end
                    PH_SIGNED_I: begin
                        if (cls.is_zero) begin
                            ctl.take     = 1'b1;
                            ctl.load_oct = 1'b1;
                            n_phase      = PH_ZERO_I;
                        end else begin
                            ctl.load_dec = 1'b1;
                            dec_force    = 1'b1;
                            do_digit     = 1'b1;
                        end
                    end
                    PH_ZERO_I: begin
                        if (cls.is_x) begin
                            ctl.take     = 1'b1;
                            ctl.load_hex = 1'b1;
                            if (w_after) begin
                                ctl.emit   = 1'b1;
                                ctl.used   = 1'b1;
                                ctl.nonnul = 1'b1;
                            end else begin
                                n_phase = PH_DIGITS;
                            end
                        end else begin
                            do_digit = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        do_digit = 1'b1;
                    end
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                if (dec_force) begin
                    dig_ok = cls.dec_ok;
                end else begin
                    case (r_radix)
                        RX_OCT:  dig_ok = cls.oct_ok;
                        RX_HEX:  dig_ok = cls.hex_ok;
                        default: dig_ok = cls.dec_ok;
                    endcase
                end

                if (do_digit) begin
                    n_phase    = PH_DIGITS;
                    ctl.nonnul = 1'b1;
                    if (w_now || !dig_ok) begin
                        ctl.emit = 1'b1;
                    end else begin
                        ctl.accum = 1'b1;
                        ctl.take  = 1'b1;
                        if (w_after) begin
                            ctl.emit = 1'b1;
                            ctl.used = 1'b1;
                        end
                    end
                end
            end
        end
        if (ctl.emit) begin
            n_phase = PH_IDLE;
        end
    end

    // datapath next values and result
    always_comb begin
        case (r_radix)
            RX_OCT:  acc_next = (r_acc << 3) + VALUE_BITS'(cls.digit);
            RX_HEX:  acc_next = (r_acc << 4) + VALUE_BITS'(cls.digit);
            default: acc_next = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(cls.digit);
        endcase

        n_acc   = r_acc;
        n_neg   = r_neg;
        n_radix = r_radix;
        n_fc    = r_fc;
        n_sc    = r_sc;
        if (ctl.start) begin
            n_acc = '0;
            n_neg = 1'b0;
            n_fc  = 8'd0;
            n_sc  = 16'd0;
            if (mode == CONV_O) begin
                n_radix = RX_OCT;
            end else if (mode == CONV_X || mode == CONV_P) begin
                n_radix = RX_HEX;
            end else begin
                n_radix = RX_DEC;
            end
        end
        if (ctl.ws) begin
            n_sc = sc_inc;
        end
        if (ctl.take) begin
            n_fc = fc_inc;
            n_sc = sc_inc;
        end
        if (ctl.set_sign) begin
            n_neg = cls.is_minus;
        end
        if (ctl.load_oct) begin
            n_radix = RX_OCT;
        end
        if (ctl.load_dec) begin
            n_radix = RX_DEC;
        end
        if (ctl.load_hex) begin
            n_radix = RX_HEX;
        end
        if (ctl.accum) begin
            n_acc = acc_next;
        end

        acc_wide   = OUT_BITS'(n_acc);
        signed_val = n_neg ? (~acc_wide + 64'd1) : acc_wide;
        sext       = (mode == CONV_D) || (mode == CONV_I);
        if (mode == CONV_P || i_cfg.length_mode == LEN_LONG) begin
            sized_val = signed_val;
        end else if (i_cfg.length_mode == LEN_SHORT) begin
            sized_val = {{48{sext & signed_val[15]}}, signed_val[15:0]};
        end else begin
            sized_val = {{32{sext & signed_val[31]}}, signed_val[31:0]};
        end

        o_res.valid    = ctl.emit;
        o_res.value    = sized_val & ValueMask;
        o_res.consumed = n_sc;
        o_res.used     = ctl.used;
        o_res.assigned = !i_cfg.suppress && ctl.nonnul;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_radix <= RX_DEC;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_fc    <= 8'd0;
            r_sc    <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_fc    <= n_fc;
            r_sc    <= n_sc;
        end
    end

    // characters while idle never produce a result
    `IFS_ASSERT_IMP(a_idle_silent, i_step && (r_phase == PH_IDLE), !o_res.valid)
    // a result always closes the field
    `IFS_ASSERT_NXT(a_emit_closes, o_res.valid, r_phase == PH_IDLE)
    // a field only opens on a start request
    `IFS_ASSERT_NXT(a_open_on_start, (r_phase == PH_IDLE) && !(i_step && (i_cmd == CMD_START)),
                    r_phase == PH_IDLE)

endmodule

// ----- hw/rtl/integer_field_scanner.sv -----
// integer field scanner top level: configuration registers, request and result stages
// depends on ifs_pkg and ifs_scan_core
`timescale 1ns / 1ps

// Scans one integer field from a stream of character requests. A start request
// (cmd 0) opens a field using the live conversion and length settings; each
// character request (cmd 1) then advances the scan by one character, and the
// request that ends the field produces exactly one result. One request is taken
// every cycle while results drain; a request is registered in the request stage
// and its result is registered in the result stage. The multiply-add of the
// accumulator is combinational and is applied once per accepted digit character.
// Write configuration only while idle.
module integer_field_scanner #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    output logic [15:0] o_consumed,
    output logic        o_last_char_used,
    output logic        o_assigned
);
    import ifs_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_ch;
    logic        r_out_valid;
    logic [63:0] r_value;
    logic [15:0] r_consumed;
    logic        r_used;
    logic        r_assigned;
    logic        advance;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CONVERSION:    r_cfg.conversion    <= i_cfg_data[2:0];
                CFG_LENGTH_MODE:   r_cfg.length_mode   <= i_cfg_data[1:0];
                CFG_WIDTH_LIMITED: r_cfg.width_limited <= i_cfg_data[0];
                CFG_MAX_WIDTH:     r_cfg.max_width     <= i_cfg_data;
                CFG_SUPPRESS:      r_cfg.suppress      <= i_cfg_data[0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // request stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd <= i_cmd;
            r_in_ch  <= i_ch;
        end
    end

    ifs_scan_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cmd   (r_in_cmd),
        .i_ch    (r_in_ch),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_value    <= res.value;
            r_consumed <= res.consumed;
            r_used     <= res.used;
            r_assigned <= res.assigned;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value          = r_value;
    assign o_consumed       = r_consumed;
    assign o_last_char_used = r_used;
    assign o_assigned       = r_assigned;

endmodule
